// ----- rtl/pdfpoc_pkg.sv -----
`default_nettype none
package pdfpoc_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int LIMIT_WIDTH = 25;
	localparam int SEEN_WIDTH  = 25;
	localparam int OUT_WIDTH   = 32;

	localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 25'(8 << 20);
	localparam logic [SEEN_WIDTH-1:0]  SEEN_MAX    = '1;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = '1;

	// page check phases
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_WS    = 3'd1;
	localparam logic [2:0] PH_PAGE1 = 3'd2;
	localparam logic [2:0] PH_PAGE5 = 3'd6;

	localparam logic [2:0] TYPE_LEN = 3'd5;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_S     = 8'h73;

	typedef struct packed {
		logic [2:0]             type_prog;
		logic [2:0]             phase;
		logic [SEEN_WIDTH-1:0]  seen;
		logic [COUNT_WIDTH-1:0] count;
	} scan_state_t;

	function automatic logic [7:0] type_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h2F;
			3'd1: c = 8'h54;
			3'd2: c = 8'h79;
			3'd3: c = 8'h70;
			3'd4: c = 8'h65;
			default: c = 8'h2F;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] page_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h2F;
			3'd1: c = 8'h50;
			3'd2: c = 8'h61;
			3'd3: c = 8'h67;
			3'd4: c = 8'h65;
			default: c = 8'h2F;
		endcase
		return c;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// clamp the count to the 32-bit report
	function automatic logic [OUT_WIDTH-1:0] report(input logic [COUNT_WIDTH-1:0] n);
		logic [63:0] wide;
		wide = 64'(n);
		return (wide > 64'hFFFF_FFFF) ? '1 : wide[OUT_WIDTH-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/pdf_page_object_counter_top.sv -----
// channel  | direction | signals                         | payload
// s_axis   | in        | tvalid tready tdata tlast       | data_byte, last_byte
// m_axis   | out       | tvalid tready tdata tuser       | page_count, pages_found
// cfg      | in        | valid ready data                | scan_byte_limit
//
// One byte per cycle while the input is not stalled. A byte is held in the input register,
// then the matchers and the count update in a single pass into the result register.
// The result register is a one-entry output buffer; input stalls only when a
// last-byte request meets a result not yet taken.
// arst_n clears the matchers, counters and valids; the limit resets to 2^23.
`default_nettype none
module pdf_page_object_counter_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic        s_axis_tlast,   // last_byte
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [31:0] m_axis_tdata,   // [31:0] page_count
	output      logic        m_axis_tuser,   // pages_found
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [24:0] cfg_data
);

	logic [pdfpoc_pkg::LIMIT_WIDTH-1:0] limit_q;
	pdfpoc_pkg::scan_state_t            st_q, st_d;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;

	logic [pdfpoc_pkg::OUT_WIDTH-1:0] out_data_q;
	logic                             out_user_q;
	logic                             out_valid_q;

	logic       examine;
	logic [2:0] ph;
	logic [2:0] tp;
	logic       type_done;
	logic       bump;
	logic [pdfpoc_pkg::COUNT_WIDTH-1:0] cnt_next;

	assign cfg_ready = 1'b1;

	assign adv           = valid_s1 && !(last_s1 && out_valid_q && !m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_comb begin
		examine   = st_q.seen < pdfpoc_pkg::SEEN_WIDTH'(limit_q);
		ph        = st_q.phase;
		tp        = st_q.type_prog;
		type_done = 1'b0;
		bump      = 1'b0;

		if (examine) begin
			if (st_q.phase == pdfpoc_pkg::PH_WS) begin
				if (pdfpoc_pkg::is_ws(byte_s1))
					ph = pdfpoc_pkg::PH_WS;
				else
					ph = (byte_s1 == pdfpoc_pkg::CH_SLASH) ? pdfpoc_pkg::PH_PAGE1
						: pdfpoc_pkg::PH_IDLE;
			end else if (st_q.phase >= pdfpoc_pkg::PH_PAGE1 &&
					st_q.phase < pdfpoc_pkg::PH_PAGE5) begin
				ph = (byte_s1 == pdfpoc_pkg::page_char(st_q.phase - 3'd1))
					? st_q.phase + 3'd1 : pdfpoc_pkg::PH_IDLE;
			end else if (st_q.phase == pdfpoc_pkg::PH_PAGE5) begin
				bump = (byte_s1 != pdfpoc_pkg::CH_S);
				ph   = pdfpoc_pkg::PH_IDLE;
			end else begin
				ph = pdfpoc_pkg::PH_IDLE;
			end

			if (tp > 3'd4)
				tp = 3'd0;
			if (byte_s1 == pdfpoc_pkg::type_char(tp)) begin
				tp = tp + 3'd1;
				if (tp == pdfpoc_pkg::TYPE_LEN) begin
					type_done = 1'b1;
					tp        = 3'd0;
				end
			end else begin
				tp = (byte_s1 == pdfpoc_pkg::CH_SLASH) ? 3'd1 : 3'd0;
			end

			if (type_done)
				ph = pdfpoc_pkg::PH_WS;
		end

		// a full /Page at end of data counts too
		if (last_s1 && ph == pdfpoc_pkg::PH_PAGE5)
			bump = 1'b1;

		cnt_next = (bump && st_q.count != pdfpoc_pkg::COUNT_MAX)
			? st_q.count + 1'b1 : st_q.count;

		st_d.type_prog = tp;
		st_d.phase     = ph;
		st_d.seen      = (examine && st_q.seen != pdfpoc_pkg::SEEN_MAX)
			? st_q.seen + 1'b1 : st_q.seen;
		st_d.count     = cnt_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= pdfpoc_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			if (last_s1)
				st_q <= '0;
			else
				st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_data_q <= pdfpoc_pkg::report(cnt_next);
			out_user_q <= (cnt_next != '0);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule
`default_nettype wire

// ----- tb/sv/pdf_page_object_counter_top_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module pdf_page_object_counter_top_tb;

	localparam logic [39:0] TYPE_TOK = "/Type";
	localparam logic [39:0] PAGE_TOK = "/Page";

	typedef struct packed {
		logic [31:0] count;
		logic        found;
	} page_report_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        typed;
		logic [31:0] count;
		logic        found;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [24:0] cfg_data = '0;

	logic                   quiet = 1'b0;
	int unsigned            errors = 0;
	int unsigned            stall_left = 0;
	page_report_t           pending_reports[$];

	// predicted scanner state
	logic [pdfpoc_pkg::LIMIT_WIDTH-1:0] scan_limit = pdfpoc_pkg::LIMIT_RESET;
	logic [2:0]                         type_prog = '0;
	logic [2:0]                         page_phase = pdfpoc_pkg::PH_IDLE;
	logic [pdfpoc_pkg::SEEN_WIDTH-1:0]  bytes_seen = '0;
	logic [31:0]                        page_total = '0;

	stim_row_t directed_rows [24] = '{
		'{8'h00, 1'b1, 1'b1, 32'd0, 1'b0},
		'{"/",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"T",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"y",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"p",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"e",   1'b0, 1'b0, 32'd0, 1'b0},
		'{8'h09, 1'b0, 1'b0, 32'd0, 1'b0},
		'{"/",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"P",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"a",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"g",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"e",   1'b1, 1'b1, 32'd1, 1'b1},
		'{"/",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"T",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"y",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"p",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"e",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"/",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"P",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"a",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"g",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"e",   1'b0, 1'b0, 32'd0, 1'b0},
		'{"s",   1'b1, 1'b0, 32'd0, 1'b0},
		'{8'hFF, 1'b1, 1'b1, 32'd0, 1'b0}
	};

	pdf_page_object_counter_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic logic [7:0] tok_char(input logic [39:0] tok, input int k);
		return tok[39 - 8 * k -: 8];
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic void bump_pages();
		if (page_total != pdfpoc_pkg::COUNT_MAX)
			page_total = page_total + 32'd1;
	endfunction

	function automatic void scan_char(input logic [7:0] c);
		logic [2:0] ph;
		ph = pdfpoc_pkg::PH_IDLE;
		if (page_phase == pdfpoc_pkg::PH_WS) begin
			if (is_blank(c))
				ph = pdfpoc_pkg::PH_WS;
			else
				ph = (c == pdfpoc_pkg::CH_SLASH) ? pdfpoc_pkg::PH_PAGE1 : pdfpoc_pkg::PH_IDLE;
		end else if (page_phase >= pdfpoc_pkg::PH_PAGE1 && page_phase < pdfpoc_pkg::PH_PAGE5) begin
			if (c == tok_char(PAGE_TOK, int'(page_phase) - int'(pdfpoc_pkg::PH_PAGE1) + 1))
				ph = page_phase + 3'd1;
		end else if (page_phase == pdfpoc_pkg::PH_PAGE5 && c != pdfpoc_pkg::CH_S) begin
			bump_pages();
		end
		if (type_prog > 3'd4)
			type_prog = '0;
		if (c == tok_char(TYPE_TOK, int'(type_prog))) begin
			if (type_prog == pdfpoc_pkg::TYPE_LEN - 3'd1) begin
				type_prog = '0;
				ph = pdfpoc_pkg::PH_WS;
			end else begin
				type_prog = type_prog + 3'd1;
			end
		end else begin
			type_prog = (c == pdfpoc_pkg::CH_SLASH) ? 3'd1 : 3'd0;
		end
		page_phase = ph;
	endfunction

	function automatic logic predict_file_byte(input logic [7:0] c, input logic last,
			output page_report_t rep);
		rep = '0;
		if (25'(bytes_seen) < scan_limit) begin
			scan_char(c);
			if (bytes_seen != pdfpoc_pkg::SEEN_MAX)
				bytes_seen = bytes_seen + 1'b1;
		end
		if (!last)
			return 1'b0;
		if (page_phase == pdfpoc_pkg::PH_PAGE5)
			bump_pages();
		rep.count = page_total;
		rep.found = (page_total != 0);
		type_prog = '0;
		page_phase = pdfpoc_pkg::PH_IDLE;
		bytes_seen = '0;
		page_total = '0;
		return 1'b1;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic push_byte(input logic [7:0] c, input logic last, input logic typed,
			input logic [31:0] typed_count, input logic typed_found);
		page_report_t rep;
		logic         emits;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		emits = predict_file_byte(c, last, rep);
		if (emits) begin
			if (typed) begin
				rep.count = typed_count;
				rep.found = typed_found;
			end
			pending_reports.push_back(rep);
		end
	endtask

	task automatic write_limit(input logic [24:0] value);
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		scan_limit = value;
	endtask

	always @(posedge clk) begin
		if (quiet) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left    <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left    <= $urandom_range(1, 8) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : watch_results
		page_report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_reports.size() == 0) begin
				flag_mismatch("unexpected result, count", m_axis_tdata, 32'd0);
			end else begin
				want = pending_reports.pop_front();
				if (m_axis_tdata !== want.count)
					flag_mismatch("page_count", m_axis_tdata, want.count);
				if (m_axis_tuser !== want.found)
					flag_mismatch("pages_found", 32'(m_axis_tuser), 32'(want.found));
			end
		end
	end

	initial begin
		#5_000_000;
		$display("pdf_page_object_counter_top regression: fail");
		$finish;
	end

	initial begin
		logic [7:0]  file_bytes[$];
		logic [24:0] lim;
		int          phase_items;
		int          files_done;
		int          kind;
		int          n;
		files_done = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			push_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
				directed_rows[i].count, directed_rows[i].found);
		s_axis_tvalid <= 1'b0;

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: lim = 25'd1;
				1: lim = 25'd0;
				2: lim = 25'd16777216;
				3: lim = 25'h1FF_FFFF;
				4: lim = 25'($urandom_range(2, 40));
				5: lim = 25'($urandom_range(1, 200));
				6: lim = 25'($urandom_range(10, 60));
				default: lim = pdfpoc_pkg::LIMIT_RESET;
			endcase
			write_limit(lim);
			phase_items = 0;
			while (phase_items < 194 || (p == 7 && files_done < 48)) begin
				file_bytes.delete();
				repeat ($urandom_range(0, 5)) begin
					kind = $urandom_range(0, 7);
					if (kind <= 5) begin
						for (int k = 0; k < 5; k++)
							file_bytes.push_back(tok_char(TYPE_TOK, k));
						repeat ($urandom_range(0, 3)) begin
							n = $urandom_range(0, 5);
							file_bytes.push_back((n == 0) ? 8'h20 : 8'(8 + n));
						end
						// kind 5: cut the page token short
						n = (kind == 5) ? $urandom_range(1, 4) : 5;
						for (int k = 0; k < n; k++)
							file_bytes.push_back(tok_char(PAGE_TOK, k));
						case ($urandom_range(0, 3))
							0: file_bytes.push_back(pdfpoc_pkg::CH_S);
							1: file_bytes.push_back(8'($urandom_range(0, 255)));
							2: ;
							default: file_bytes.push_back(8'h20);
						endcase
					end else if (kind == 6) begin
						n = $urandom_range(1, 4);
						for (int k = 0; k < n; k++)
							file_bytes.push_back(tok_char(TYPE_TOK, k));
						file_bytes.push_back(8'($urandom_range(0, 255)));
					end else begin
						repeat ($urandom_range(1, 6))
							file_bytes.push_back(8'($urandom_range(0, 255)));
					end
				end
				if (file_bytes.size() == 0)
					file_bytes.push_back(8'($urandom_range(0, 255)));
				foreach (file_bytes[i]) begin
					push_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, 32'd0, 1'b0);
					phase_items++;
				end
				files_done++;
				if (p == 7 && phase_items >= 100)
					quiet <= 1'b1;
			end
			s_axis_tvalid <= 1'b0;
		end

		while (pending_reports.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0 && pending_reports.size() == 0) begin
			$display("pdf_page_object_counter_top regression: pass");
		end else begin
			$display("pdf_page_object_counter_top regression: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/pdfpoc_pkg.sv
rtl/pdf_page_object_counter_top.sv
tb/sv/pdf_page_object_counter_top_tb.sv
